// File: src/ptms_pkg.sv
// Shared constants, codes and types for the priority table with max select.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ptms_pkg;

  // Table geometry.
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

  // One table entry.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a new transaction
    logic scan;    // walk the table
    logic finish;  // commit state and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;  // more table reads to issue
    logic pipe_busy;  // a read result is still being processed
    logic out_busy;   // result register holds an untaken transaction
  } dp_stat_t;

endpackage

// File: src/ptms_req_if.sv
// Command channel interface: valid/ready handshake with the command payload.
// Depends on ptms_pkg.
interface ptms_req_if import ptms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] handle;
  logic [PRIO_W-1:0]   prio;

  modport source (output valid, output cmd, output handle, output prio, input ready);
  modport sink   (input valid, input cmd, input handle, input prio, output ready);
endinterface

// File: src/ptms_rsp_if.sv
// Result channel interface: valid/ready handshake with the result payload.
// Depends on ptms_pkg.
interface ptms_rsp_if import ptms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] best_handle;
  logic [PRIO_W-1:0]   best_prio;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output best_handle, output best_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input best_handle, input best_prio,
                  input occupancy, output ready);
endinterface

// File: src/ptms_ctrl.sv
// Controller state machine: sequences one transaction at a time through
// latch, table walk and commit. Depends on ptms_pkg.
module ptms_ctrl import ptms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Accept only when idle and the previous result has been taken.
  assign req_ready = (state == S_IDLE) && !stat.out_busy;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          ctl.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (!stat.scan_more && !stat.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/ptms_datapath.sv
// Datapath: entry memory, entry count, table walk with compaction on remove,
// maximum tracking on query, and the result register. Depends on ptms_pkg.
module ptms_datapath import ptms_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            ctl,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    req_cmd,
  input  logic [HANDLE_W-1:0] req_handle,
  input  logic [PRIO_W-1:0]   req_prio,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output logic [STATUS_W-1:0] rsp_status,
  output logic [HANDLE_W-1:0] rsp_best_handle,
  output logic [PRIO_W-1:0]   rsp_best_prio,
  output logic [OCC_W-1:0]    rsp_occupancy
);

  entry_t              mem [CAPACITY];
  entry_t              rd_data;
  logic [CMD_W-1:0]    op;
  logic [HANDLE_W-1:0] key_handle;
  logic [PRIO_W-1:0]   key_prio;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    pipe_idx;
  logic [CNT_W-1:0]    pipe_idx_m1;
  logic                pipe_v;
  logic                found;
  logic [HANDLE_W-1:0] best_handle;
  logic [PRIO_W-1:0]   best_prio;
  logic                scan_op;
  logic                issue;
  logic                full;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [PRIO_W-1:0]   res_prio;

  // Walk control: remove and query read every live entry once.
  assign scan_op = (op == CMD_REMOVE) || (op == CMD_QUERY);
  assign issue   = ctl.scan && scan_op && (rd_idx < count);
  assign full    = (count >= CNT_W'(CAPACITY));

  assign stat.scan_more = scan_op && (rd_idx < count);
  assign stat.pipe_busy = pipe_v;
  assign stat.out_busy  = rsp_valid;

  assign pipe_idx_m1 = pipe_idx - CNT_W'(1);

  // Single write port: compaction during a remove walk, append on add commit.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pipe_idx_m1[ADDR_W-1:0];
    wr_data = rd_data;
    if (pipe_v && (op == CMD_REMOVE) && found) begin
      wr_en = 1'b1;
    end else if (ctl.finish && (op == CMD_ADD) && !full) begin
      wr_en          = 1'b1;
      wr_addr        = count[ADDR_W-1:0];
      wr_data.handle = key_handle;
      wr_data.prio   = key_prio;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // Result and count for the commit cycle.
  always_comb begin
    res_status = ST_OK;
    res_handle = '0;
    res_prio   = '0;
    count_next = count;
    case (op)
      CMD_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_QUERY: begin
        if (best_prio == '0) begin
          res_status = ST_NONE;
        end else begin
          res_handle = best_handle;
          res_prio   = best_prio;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Transaction registers, walk pipeline, match and maximum tracking.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op          <= req_cmd;
      key_handle  <= req_handle;
      key_prio    <= req_prio;
      rd_idx      <= '0;
      found       <= 1'b0;
      best_handle <= '0;
      best_prio   <= '0;
    end else begin
      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (pipe_v) begin
        if (op == CMD_REMOVE && !found && rd_data.handle == key_handle) begin
          found <= 1'b1;
        end
        if (op == CMD_QUERY && rd_data.prio > best_prio) begin
          best_prio   <= rd_data.prio;
          best_handle <= rd_data.handle;
        end
      end
    end
    pipe_idx <= rd_idx;
  end

  // Control registers: count, pipeline valid, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pipe_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pipe_v <= issue;
      if (ctl.finish) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rsp_status      <= res_status;
      rsp_best_handle <= res_handle;
      rsp_best_prio   <= res_prio;
      rsp_occupancy   <= OCC_W'(count_next);
    end
  end

endmodule

// File: src/priority_table_max_select.sv
// Top level of the priority table with max select: controller plus datapath.
// Depends on ptms_pkg, ptms_req_if, ptms_rsp_if, ptms_ctrl and ptms_datapath.
//
//   Channel  Direction  Payload
//   req      in         cmd, handle, prio
//   rsp      out        status, best_handle, best_prio, occupancy
//
// One command is handled at a time. Add and unknown codes pass through the walk state
// without reading the table and raise the result valid from the commit state. Remove and
// query walk the table one entry per cycle through the single memory read port and raise
// it once the last read result has been processed.
// The next command is accepted once the controller is idle and the result
// register has been taken. Reset clears the entry count and the control state;
// the memory contents are not cleared.
module priority_table_max_select import ptms_pkg::*; (
  input logic      clk,
  input logic      rst,
  ptms_req_if.sink   req,
  ptms_rsp_if.source rsp
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  ptms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ptms_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .req_cmd         (req.cmd),
    .req_handle      (req.handle),
    .req_prio        (req.prio),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_best_handle (rsp.best_handle),
    .rsp_best_prio   (rsp.best_prio),
    .rsp_occupancy   (rsp.occupancy)
  );

`ifndef NO_ASSERTIONS
  // A new transaction is never taken while a result is still pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !rsp.valid)
    else $error("command accepted while a result was pending");

  // After acceptance the block is busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready stayed high after a command was accepted");

  // A full report only occurs with the table at capacity.
  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(CAPACITY)))
    else $error("table full reported below capacity");

  // A nonzero priority only comes with an OK status, as on a successful query.
  a_prio_only_query: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.best_prio == '0))
    else $error("nonzero priority on an unsuccessful result");
`endif

endmodule

// File: tb/tb_priority_table_max_select.sv
// Self-checking testbench for priority_table_max_select: directed and random commands
// against a table predictor held in a small scoreboard class.
// Depends on ptms_pkg, ptms_req_if, ptms_rsp_if and the priority_table_max_select RTL.
module tb_priority_table_max_select;
  import ptms_pkg::*;

  // Code 3 is not named in the package; the block treats it as a no-op.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam int RANDOM_ITEMS = 1180;
  localparam int LONG_HOLD    = 400;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_MIXED } traffic_mix_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] best_handle;
    logic [PRIO_W-1:0]   best_prio;
    logic [OCC_W-1:0]    occupancy;
  } table_result_t;

  // Shadow copy of the table, the queue of predicted results and the run statistics.
  class table_scoreboard;
    logic [HANDLE_W-1:0] handles [CAPACITY];
    logic [PRIO_W-1:0]   prios   [CAPACITY];
    int unsigned         count;
    table_result_t       expected_q[$];
    int unsigned         errors;
    int unsigned         n_checked;
    int unsigned         n_cmd    [4];
    int unsigned         n_status [4];

    function new();
      count     = 0;
      errors    = 0;
      n_checked = 0;
      foreach (n_cmd[i]) n_cmd[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply one accepted command to the shadow table and queue its result.
    function void note_command(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h,
                               logic [PRIO_W-1:0] p);
      table_result_t want;
      int            pos;
      want = '0;
      want.status = ST_OK;
      case (c)
        CMD_ADD: begin
          if (count >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            handles[count] = h;
            prios[count]   = p;
            count++;
          end
        end
        CMD_REMOVE: begin
          pos = -1;
          for (int i = 0; i < count; i++) begin
            if (handles[i] == h) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            want.status = ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < count; i++) begin
              handles[i] = handles[i+1];
              prios[i]   = prios[i+1];
            end
            count--;
          end
        end
        CMD_QUERY: begin
          // Strictly greater keeps the lowest position on a tie.
          for (int i = 0; i < count; i++) begin
            if (prios[i] > want.best_prio) begin
              want.best_prio   = prios[i];
              want.best_handle = handles[i];
            end
          end
          if (want.best_prio == '0) begin
            want.status      = ST_NONE;
            want.best_handle = '0;
          end
        end
        default: ;
      endcase
      want.occupancy = OCC_W'(count);
      n_cmd[c]++;
      n_status[want.status]++;
      expected_q.push_back(want);
    endfunction

    // Compare one accepted result with the oldest prediction.
    task check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with status %0d arrived with nothing outstanding",
                         got.status));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         n_checked, got.status, want.status));
      if (got.best_handle !== want.best_handle)
        report($sformatf("result %0d: best_handle %h, expected %h",
                         n_checked, got.best_handle, want.best_handle));
      if (got.best_prio !== want.best_prio)
        report($sformatf("result %0d: best_prio %h, expected %h",
                         n_checked, got.best_prio, want.best_prio));
      if (got.occupancy !== want.occupancy)
        report($sformatf("result %0d: occupancy %0d, expected %0d",
                         n_checked, got.occupancy, want.occupancy));
    endtask
  endclass

  logic clk;
  logic rst;

  ptms_req_if req();
  ptms_rsp_if rsp();

  priority_table_max_select DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  table_scoreboard board = new();

  // Long back-pressure requests from the stimulus, served by the receiver process.
  int unsigned hold_requests = 0;

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Safety net against a hung block.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", board.expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Result side: a stall pattern drawn anew each time the phase counter wraps, plus long hold-offs.
  initial begin : rsp_ready_drive
    int unsigned     hold_served;
    int unsigned     hold_left;
    int unsigned     phase;
    int unsigned     stall_mode;
    logic [15:0]     pattern;
    hold_served = 0;
    hold_left   = 0;
    phase       = 0;
    stall_mode  = 0;
    pattern     = 16'hB5C3;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (phase == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern    = 16'($urandom);
      end
      phase = (phase + 1) % 64;
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp.ready <= 1'b1;
          1: begin
            rsp.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
          2: rsp.ready <= 1'($urandom_range(0, 1));
          default: rsp.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check every result transaction.
  always @(posedge clk) begin : rsp_monitor
    table_result_t seen;
    if (!rst && rsp.valid && rsp.ready) begin
      seen.status      = rsp.status;
      seen.best_handle = rsp.best_handle;
      seen.best_prio   = rsp.best_prio;
      seen.occupancy   = rsp.occupancy;
      board.check_result(seen);
    end
  end

  // Offer one command and hold it until the block takes it.
  task automatic send_command(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h,
                              logic [PRIO_W-1:0] p);
    req.valid  <= 1'b1;
    req.cmd    <= c;
    req.handle <= h;
    req.prio   <= p;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_command(c, h, p);
  endtask

  // Drop valid for a number of cycles, with junk on the payload.
  task automatic idle_sender(int unsigned cycles);
    if (cycles == 0) return;
    req.valid  <= 1'b0;
    req.cmd    <= CMD_W'($urandom);
    req.handle <= HANDLE_W'($urandom);
    req.prio   <= PRIO_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering until every predicted result has been taken.
  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (board.expected_q.size() != 0);
  endtask

  // Handles lean toward a small pool, so duplicates and matches happen often.
  function automatic logic [HANDLE_W-1:0] random_handle();
    case ($urandom_range(0, 3))
      0: return HANDLE_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return HANDLE_W'($urandom);
    endcase
  endfunction

  // Priorities lean toward zero, ties and the top value.
  function automatic logic [PRIO_W-1:0] random_prio();
    case ($urandom_range(0, 5))
      0, 1: return PRIO_W'($urandom_range(0, 3));
      2: return '1;
      3: return '0;
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  // Choose a command code for the given traffic mix.
  function automatic logic [CMD_W-1:0] random_cmd(traffic_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return roll < 85 ? CMD_ADD : roll < 95 ? CMD_QUERY : CMD_NOP;
      MIX_DRAIN: return roll < 70 ? CMD_REMOVE : roll < 90 ? CMD_QUERY :
                        roll < 95 ? CMD_ADD : CMD_NOP;
      default:   return roll < 40 ? CMD_ADD : roll < 70 ? CMD_REMOVE :
                        roll < 95 ? CMD_QUERY : CMD_NOP;
    endcase
  endfunction

  // Stimulus: directed corner cases, then random rounds of fill, drain and mixed traffic.
  initial begin : stimulus
    int unsigned         issued;
    int unsigned         round;
    int unsigned         round_len;
    int unsigned         burst_left;
    int unsigned         waited;
    traffic_mix_t        mix;
    logic [CMD_W-1:0]    c;
    logic [HANDLE_W-1:0] h;
    logic [PRIO_W-1:0]   p;

    req.valid  <= 1'b0;
    req.cmd    <= CMD_ADD;
    req.handle <= '0;
    req.prio   <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Empty table, zero priority, field extremes, ties and duplicate handles.
    send_command(CMD_QUERY,  16'h0000, 16'h0000);
    send_command(CMD_REMOVE, 16'h1234, 16'h0000);
    send_command(CMD_NOP,    16'h0000, 16'h0000);
    send_command(CMD_ADD,    16'h0000, 16'h0000);
    send_command(CMD_QUERY,  16'hFFFF, 16'hFFFF);
    send_command(CMD_ADD,    16'hFFFF, 16'hFFFF);
    send_command(CMD_ADD,    16'h0001, 16'hFFFF);
    send_command(CMD_QUERY,  16'h0000, 16'h0000);
    send_command(CMD_ADD,    16'hAAAA, 16'h5555);
    send_command(CMD_ADD,    16'h5555, 16'hAAAA);
    send_command(CMD_ADD,    16'hAAAA, 16'h0001);
    send_command(CMD_REMOVE, 16'hAAAA, 16'hFFFF);
    send_command(CMD_QUERY,  16'h0000, 16'h0000);
    send_command(CMD_REMOVE, 16'hFFFF, 16'h0000);
    send_command(CMD_QUERY,  16'h0000, 16'h0000);
    send_command(CMD_REMOVE, 16'h7777, 16'h0000);
    send_command(CMD_NOP,    16'hFFFF, 16'hFFFF);
    send_command(CMD_REMOVE, 16'h0001, 16'h0000);
    send_command(CMD_REMOVE, 16'h5555, 16'h0000);
    send_command(CMD_REMOVE, 16'hAAAA, 16'h0000);
    send_command(CMD_REMOVE, 16'h0000, 16'h0000);
    send_command(CMD_QUERY,  16'h0000, 16'h0000);

    // The first round fills the table past capacity; later rounds vary the mix.
    issued     = 0;
    round      = 0;
    burst_left = $urandom_range(1, 24);
    while (issued < RANDOM_ITEMS) begin
      if (round == 0) begin
        mix       = MIX_FILL;
        round_len = 180;
      end else begin
        mix       = traffic_mix_t'($urandom_range(0, 2));
        round_len = $urandom_range(30, 150);
      end
      // Hold the result side off for a long stretch while commands keep coming.
      if (round == 1 || $urandom_range(0, 7) == 0) hold_requests++;
      for (int k = 0; k < round_len && issued < RANDOM_ITEMS; k++) begin
        c = random_cmd(mix);
        h = random_handle();
        p = random_prio();
        if (c == CMD_REMOVE && board.count != 0 && $urandom_range(0, 4) != 0)
          h = board.handles[$urandom_range(0, board.count - 1)];
        send_command(c, h, p);
        if (c != CMD_NOP) issued++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          idle_sender($urandom_range(0, 3) == 0 ? $urandom_range(10, 60)
                                                : $urandom_range(0, 6));
        end
      end
      // Let the block run dry now and then.
      if (round == 2 || $urandom_range(0, 3) == 0) wait_for_results();
      round++;
    end

    // Drain, then allow one full table walk for anything unexpected.
    req.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (board.expected_q.size() != 0 && waited < 200_000);
    repeat (CAPACITY + 8) @(posedge clk);
    if (board.expected_q.size() != 0)
      board.report($sformatf("%0d results never arrived", board.expected_q.size()));

    $display("Covered %0d adds (%0d on a full table), %0d removes (%0d without a match),",
             board.n_cmd[CMD_ADD], board.n_status[ST_FULL], board.n_cmd[CMD_REMOVE],
             board.n_status[ST_NOT_FOUND]);
    $display("%0d queries (%0d with nothing above zero), %0d no-ops; %0d results checked.",
             board.n_cmd[CMD_QUERY], board.n_status[ST_NONE], board.n_cmd[CMD_NOP],
             board.n_checked);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ptms_pkg.sv
src/ptms_req_if.sv
src/ptms_rsp_if.sv
src/ptms_ctrl.sv
src/ptms_datapath.sv
src/priority_table_max_select.sv
tb/tb_priority_table_max_select.sv
